/* rtl/cgn_pkg.sv */
// shared types and constants of the canny gradient and suppression block
package cgn_pkg;

  localparam int FW_W    = 11;  // frame_width register width
  localparam int FH_W    = 13;  // frame_height register width
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int PIX_W   = 8;
  localparam int MAG2_W  = 17;  // squared magnitude, at most 2*255*255
  localparam int EDGE_W  = 9;
  localparam int DIR_W   = 2;
  localparam int GRAD_W  = MAG2_W + DIR_W;

  localparam logic [FW_W-1:0] FW_RESET = FW_W'(512);
  localparam logic [FH_W-1:0] FH_RESET = FH_W'(512);
  localparam int MIN_SIZE = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam logic [DIR_W-1:0] DIR_0   = 2'd0;
  localparam logic [DIR_W-1:0] DIR_45  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_90  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_135 = 2'd3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;     // take the pixel, write it to the pixel line
    logic rd_pix;     // read the two upper-row pixels
    logic calc_grad;  // form the forward differences
    logic wr_grad;    // store magnitude and direction, read center entry
    logic rd_nbr;     // read both neighbours, start the root
    logic load_out;   // move the result to the output register
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic first;      // no pixel of the frame taken yet
    logic in_frame;   // frame still needs pixels
    logic has_out;    // current item yields a result
    logic root_done;
    logic out_free;
  } sts_t;

endpackage

/* rtl/cgn_ifs.sv */
// handshake channel interfaces for the input pixels and the results
interface cgn_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [cgn_pkg::PIX_W-1:0]     pixel;

  modport source (output valid, output kind, output pixel, input ready);
  modport sink   (input valid, input kind, input pixel, output ready);
endinterface

interface cgn_out_if;
  logic                          valid;
  logic                          ready;
  logic [cgn_pkg::EDGE_W-1:0]    edge_magnitude;
  logic [cgn_pkg::DIR_W-1:0]     direction;
  logic                          last_of_frame;

  modport source (output valid, output edge_magnitude, output direction,
                  output last_of_frame, input ready);
  modport sink   (input valid, input edge_magnitude, input direction,
                  input last_of_frame, output ready);
endinterface

/* rtl/cgn_isqrt.sv */
// bit-serial integer square root, one result bit per cycle
module cgn_isqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [cgn_pkg::MAG2_W-1:0] din,
  output logic                       done,
  output logic [cgn_pkg::EDGE_W-1:0] root
);

  localparam int VW = cgn_pkg::MAG2_W;
  localparam int RW = VW + 1;
  localparam int CNTW = $clog2(cgn_pkg::EDGE_W + 1);

  logic [VW-1:0]   v_r, v_nxt;
  logic [RW-1:0]   r_r, r_nxt;
  logic [VW-1:0]   bit_r;
  logic [CNTW-1:0] cnt_r;
  logic [RW-1:0]   trial;

  assign trial = r_r + RW'(bit_r);

  always_comb begin
    v_nxt = v_r;
    r_nxt = r_r >> 1;
    if (RW'(v_r) >= trial) begin
      v_nxt = v_r - VW'(trial);
      r_nxt = (r_r >> 1) + RW'(bit_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNTW'(cgn_pkg::EDGE_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= din;
      r_r   <= '0;
      bit_r <= VW'(1) << (VW - 1);
    end else if (cnt_r != '0) begin
      v_r   <= v_nxt;
      r_r   <= r_nxt;
      bit_r <= bit_r >> 2;
    end
  end

  assign done = (cnt_r == '0);
  assign root = r_r[cgn_pkg::EDGE_W-1:0];

endmodule

/* rtl/cgn_datapath.sv */
// line buffers, counters, gradient arithmetic and output register
module cgn_datapath #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cgn_pkg::cmd_t                   cmd,
  output cgn_pkg::sts_t                   sts,
  input  logic [cgn_pkg::PIX_W-1:0]       in_pixel,
  input  logic                            cfg_we,
  input  logic [cgn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cgn_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [cgn_pkg::EDGE_W-1:0]      out_edge_magnitude,
  output logic [cgn_pkg::DIR_W-1:0]       out_direction,
  output logic                            out_last_of_frame
);

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int CW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 1);
  localparam int PW    = $clog2(2 * MAX_WIDTH + 4);
  localparam int DEPTH = 1 << PW;
  localparam int MW    = cgn_pkg::MAG2_W;
  localparam int GW    = cgn_pkg::GRAD_W;

  logic [cgn_pkg::FW_W-1:0] frame_width_r;
  logic [cgn_pkg::FH_W-1:0] frame_height_r;
  logic [WW-1:0] w_r, w_clamp, cn_r, mcol_r;
  logic [HW-1:0] h_r, h_clamp, rn_r;
  logic [CW-1:0] total_r, t_r, n_r;
  logic [cgn_pkg::PIX_W-1:0] v_nxt, v_r, pm_q, pr_q, right;
  logic signed [8:0] gx_r, gy_r;

  logic [cgn_pkg::PIX_W-1:0] pix_mem [DEPTH];
  logic [GW-1:0]             grad_mem [DEPTH];
  logic [GW-1:0]             gn_q, ga_q, gb_q;

  logic [PW-1:0] t_addr, m_addr, n_addr, wa, a_addr, b_addr;
  logic          has_grad, last, interior, keep;

  // direction and magnitude
  logic signed [9:0] y0, x0, y1, x1, gxa_s, ax_s;
  logic [7:0]        gxa, ax;
  logic [9:0]        ysum, ydiff;
  logic [19:0]       sq_sum, sq_diff;
  logic [15:0]       gx2, ax2;
  logic [19:0]       two_ax2;
  logic [MW-1:0]     mag2;
  logic [cgn_pkg::DIR_W-1:0] dir_new;

  logic                      root_done;
  logic [cgn_pkg::EDGE_W-1:0] root;

  logic                       out_valid_r;
  logic [cgn_pkg::EDGE_W-1:0] out_edge_r;
  logic [cgn_pkg::DIR_W-1:0]  out_dir_r;
  logic                       out_last_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= cgn_pkg::FW_RESET;
      frame_height_r <= cgn_pkg::FH_RESET;
    end else if (cfg_we) begin
      if (cfg_index == cgn_pkg::CFG_FRAME_WIDTH) begin
        frame_width_r <= cfg_wdata[cgn_pkg::FW_W-1:0];
      end else if (cfg_index == cgn_pkg::CFG_FRAME_HEIGHT) begin
        frame_height_r <= cfg_wdata[cgn_pkg::FH_W-1:0];
      end
    end
  end

  always_comb begin
    if (32'(frame_width_r) < 32'(cgn_pkg::MIN_SIZE)) w_clamp = WW'(cgn_pkg::MIN_SIZE);
    else if (32'(frame_width_r) > 32'(MAX_WIDTH)) w_clamp = WW'(MAX_WIDTH);
    else w_clamp = WW'(frame_width_r);
    if (32'(frame_height_r) < 32'(cgn_pkg::MIN_SIZE)) h_clamp = HW'(cgn_pkg::MIN_SIZE);
    else if (32'(frame_height_r) > 32'(MAX_HEIGHT)) h_clamp = HW'(MAX_HEIGHT);
    else h_clamp = HW'(frame_height_r);
  end

  assign sts.first     = (t_r == '0);
  assign sts.in_frame  = (t_r < total_r);
  assign has_grad      = (t_r >= CW'(w_r));
  assign sts.has_out   = (t_r >= CW'({w_r, 1'b1}));
  assign sts.root_done = root_done;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign v_nxt  = (sts.first || sts.in_frame) ? in_pixel : '0;
  assign t_addr = t_r[PW-1:0];
  assign wa     = PW'(w_r);
  assign m_addr = t_addr - wa;
  assign n_addr = n_r[PW-1:0];
  assign right  = (mcol_r == w_r - 1'b1) ? '0 : pr_q;

  // quantized direction of atan2(-gx, gy), folded to y >= 0
  always_comb begin
    y0 = -10'(gx_r);
    x0 = 10'(gy_r);
    if (y0 < 0) begin
      y1 = -y0;
      x1 = -x0;
    end else begin
      y1 = y0;
      x1 = x0;
    end
    ax_s  = (x1 < 0) ? -x1 : x1;
    gxa_s = (gx_r < 0) ? -10'(gx_r) : 10'(gx_r);
    ax    = ax_s[7:0];
    gxa   = gxa_s[7:0];
    ysum  = 10'(y1 + ax_s);
    ydiff = 10'(y1 - ax_s);
    sq_sum  = 20'(ysum) * 20'(ysum);
    sq_diff = 20'(ydiff) * 20'(ydiff);
    ax2  = 16'(ax) * 16'(ax);
    gx2  = 16'(gxa) * 16'(gxa);
    two_ax2 = {3'b000, ax2, 1'b0};
    mag2 = MW'(gx2) + MW'(ax2);
    if (sq_sum <= two_ax2) dir_new = cgn_pkg::DIR_0;
    else if (y1 >= ax_s && sq_diff >= two_ax2) dir_new = cgn_pkg::DIR_90;
    else if (x1 > 0) dir_new = cgn_pkg::DIR_45;
    else dir_new = cgn_pkg::DIR_135;
  end

  // neighbours along the stored direction
  always_comb begin
    unique case (gn_q[cgn_pkg::DIR_W-1:0])
      cgn_pkg::DIR_0: begin
        a_addr = n_addr - PW'(1);
        b_addr = n_addr + PW'(1);
      end
      cgn_pkg::DIR_45: begin
        a_addr = n_addr - wa + PW'(1);
        b_addr = n_addr + wa - PW'(1);
      end
      cgn_pkg::DIR_90: begin
        a_addr = n_addr - wa;
        b_addr = n_addr + wa;
      end
      default: begin
        a_addr = n_addr - wa - PW'(1);
        b_addr = n_addr + wa + PW'(1);
      end
    endcase
  end

  // line memories
  always_ff @(posedge clk) begin
    if (cmd.accept) pix_mem[t_addr] <= v_nxt;
    if (cmd.rd_pix) begin
      pm_q <= pix_mem[m_addr];
      pr_q <= pix_mem[m_addr + PW'(1)];
    end
    if (cmd.wr_grad && has_grad) grad_mem[m_addr] <= {mag2, dir_new};
    if (cmd.wr_grad) gn_q <= grad_mem[n_addr];
    if (cmd.rd_nbr) begin
      ga_q <= grad_mem[a_addr];
      gb_q <= grad_mem[b_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) v_r <= v_nxt;
    if (cmd.rd_pix) total_r <= CW'(w_r) * CW'(h_r);
    if (cmd.calc_grad) begin
      gx_r <= $signed({1'b0, pm_q}) - $signed({1'b0, v_r});
      gy_r <= $signed({1'b0, pm_q}) - $signed({1'b0, right});
    end
  end

  cgn_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.rd_nbr),
    .din   (gn_q[GW-1:cgn_pkg::DIR_W]),
    .done  (root_done),
    .root  (root)
  );

  assign last     = (n_r + 1'b1 == total_r);
  assign interior = (rn_r != '0) && ((HW + 1)'(rn_r) + 1'b1 < (HW + 1)'(h_r)) &&
                    (cn_r != '0) && ((WW + 1)'(cn_r) + 1'b1 < (WW + 1)'(w_r));
  assign keep     = !((gn_q[GW-1:cgn_pkg::DIR_W] < ga_q[GW-1:cgn_pkg::DIR_W]) ||
                      (gn_q[GW-1:cgn_pkg::DIR_W] < gb_q[GW-1:cgn_pkg::DIR_W]));

  // frame counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r    <= WW'(512 > MAX_WIDTH ? MAX_WIDTH : 512);
      h_r    <= HW'(512 > MAX_HEIGHT ? MAX_HEIGHT : 512);
      t_r    <= '0;
      n_r    <= '0;
      rn_r   <= '0;
      cn_r   <= '0;
      mcol_r <= '0;
    end else begin
      if (cmd.accept && sts.first) begin
        w_r <= w_clamp;
        h_r <= h_clamp;
      end
      if (cmd.wr_grad) begin
        t_r <= t_r + 1'b1;
        if (has_grad) mcol_r <= (mcol_r == w_r - 1'b1) ? '0 : mcol_r + 1'b1;
      end
      if (cmd.load_out) begin
        if (last) begin
          t_r    <= '0;
          n_r    <= '0;
          rn_r   <= '0;
          cn_r   <= '0;
          mcol_r <= '0;
        end else begin
          n_r <= n_r + 1'b1;
          if (cn_r == w_r - 1'b1) begin
            cn_r <= '0;
            rn_r <= rn_r + 1'b1;
          end else begin
            cn_r <= cn_r + 1'b1;
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_edge_r <= (interior && keep) ? root : '0;
      out_dir_r  <= gn_q[cgn_pkg::DIR_W-1:0];
      out_last_r <= last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_edge_magnitude = out_edge_r;
  assign out_direction      = out_dir_r;
  assign out_last_of_frame  = out_last_r;

endmodule

/* rtl/cgn_ctrl.sv */
// sequencing state machine for one beat at a time
module cgn_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_kind,
  output logic          in_ready,
  input  cgn_pkg::sts_t sts,
  output cgn_pkg::cmd_t cmd
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_PRD  = 7'b0000010,
    ST_GRAD = 7'b0000100,
    ST_STORE = 7'b0001000,
    ST_NBR  = 7'b0010000,
    ST_ROOT = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   take;

  assign in_ready = (state_r == ST_IDLE);
  // a flush while pixels are still due is dropped without effect
  assign take = in_valid && in_ready && !(in_kind && (sts.first || sts.in_frame));

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_PRD;
        end
      end
      ST_PRD: begin
        cmd.rd_pix = 1'b1;
        state_nxt  = ST_GRAD;
      end
      ST_GRAD: begin
        cmd.calc_grad = 1'b1;
        state_nxt     = ST_STORE;
      end
      ST_STORE: begin
        cmd.wr_grad = 1'b1;
        state_nxt   = sts.has_out ? ST_NBR : ST_IDLE;
      end
      ST_NBR: begin
        cmd.rd_nbr = 1'b1;
        state_nxt  = ST_ROOT;
      end
      ST_ROOT: begin
        if (sts.root_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

endmodule

/* rtl/canny_gradient_nms_unit.sv */
// top level of the canny gradient and non-maximum suppression block
//
// usage: pixels of a frame arrive in raster order on in_bus (kind 0), one
// beat each; after the last pixel, flush beats (kind 1) drain the results
// still held back. a flush beat while pixels are still due is taken and
// dropped. each result beat on out_bus carries the suppressed edge
// magnitude, the quantized direction and a last-of-frame flag.
// the result of pixel n leaves on the beat that follows 2*W+1 beats later,
// so a frame of W*H pixels needs 2*W+1 flush beats to finish.
// an item that yields no result passes the states idle, pixel read, difference
// and store; one that yields a result then reads the neighbours, runs the 9
// iterations of the bit-serial square root and waits for a free output register.
// frame size is taken from cfg_* writes when a frame's first pixel comes in.
// reset (rst_n low, synchronous) empties the frame counters and output
// register and loads 512 x 512; the line memories need no clearing.
// a stalled receiver holds the result in the output register; the block
// still takes the next beat and stops only if a second result is ready.
module canny_gradient_nms_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  cgn_in_if.sink                         in_bus,
  cgn_out_if.source                      out_bus,
  input  logic                           cfg_we,
  input  logic [cgn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cgn_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  cgn_pkg::cmd_t cmd;
  cgn_pkg::sts_t sts;
  logic          in_ready;

  // sequencer: one beat at a time through read, difference, store, neighbour read, root, output load
  cgn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_kind  (in_bus.kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign in_bus.ready = in_ready;

  // line memories, counters and arithmetic
  cgn_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_pixel           (in_bus.pixel),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_bus.valid),
    .out_ready          (out_bus.ready),
    .out_edge_magnitude (out_bus.edge_magnitude),
    .out_direction      (out_bus.direction),
    .out_last_of_frame  (out_bus.last_of_frame)
  );

endmodule

/* rtl/cgn_checker.sv */
// port-level checks of the block, bound to the top level
module cgn_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [cgn_pkg::EDGE_W-1:0] out_edge_magnitude,
  input logic [cgn_pkg::DIR_W-1:0]  out_direction,
  input logic                       out_last_of_frame
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_edge_magnitude) &&
      $stable(out_direction) && $stable(out_last_of_frame))
    else $error("result changed while stalled");

  a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_edge_magnitude <= 9'd360)
    else $error("edge magnitude out of range");

  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result right after a beat was taken");

endmodule

bind canny_gradient_nms_unit cgn_checker u_cgn_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_bus.valid),
  .in_ready           (in_bus.ready),
  .out_valid          (out_bus.valid),
  .out_ready          (out_bus.ready),
  .out_edge_magnitude (out_bus.edge_magnitude),
  .out_direction      (out_bus.direction),
  .out_last_of_frame  (out_bus.last_of_frame)
);
